FILE: hdl/spq_pkg.sv
package spq_pkg;

   // Default sizes of the queue
   localparam int SPQ_DEPTH    = 16;
   localparam int SPQ_KEY_BITS = 16;
   localparam int SPQ_TAG_BITS = 16;

   // Opcodes of a request
   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_POLL  = 1'b1;

   // Request payload
   typedef struct packed {
      logic        opcode;
      logic [15:0] priority_key;
      logic [15:0] task_tag;
   } spq_req_type;

   // Response payload
   typedef struct packed {
      logic [15:0] polled_tag;
      logic        polled_valid;
      logic        offer_dropped;
      logic [15:0] head_tag;
      logic        head_valid;
      logic [4:0]  entry_count;
   } spq_rsp_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic remove;
   } spq_cmd_type;

endpackage

FILE: hdl/spq_cell.sv
module spq_cell #(
   parameter int KEY_BITS = spq_pkg::SPQ_KEY_BITS,
   parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
   input  logic                clock,
   input  spq_pkg::spq_cmd_type cmd,
   input  logic                occupied,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic                left_keep,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [TAG_BITS-1:0] left_tag,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [TAG_BITS-1:0] right_tag,
   output logic                keep,
   output logic [KEY_BITS-1:0] key,
   output logic [TAG_BITS-1:0] tag,
   output logic [TAG_BITS-1:0] tag_next
);
   import spq_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // Hold the entry when it sorts at or before the new key
   assign keep = occupied && (key_ff <= new_key);

   // Pick the next entry: hold, take the new item, or shift from a neighbor
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (cmd.insert) begin
         if (!keep) begin
            if (left_keep) begin
               key_in = new_key;
               tag_in = new_tag;
            end else begin
               key_in = left_key;
               tag_in = left_tag;
            end
         end
      end else if (cmd.remove) begin
         key_in = right_key;
         tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key      = key_ff;
   assign tag      = tag_ff;
   assign tag_next = tag_in;

endmodule

FILE: hdl/sorted_priority_queue.sv
// Channel  | Direction | Ports                        | Payload
// request  | in        | req_valid, req_ready         | spq_req_type (opcode, key, tag)
// response | out       | rsp_valid, rsp_ready         | spq_rsp_type (polled, head, count)
//
// One request per cycle: every cell of the chain compares its key with the
// offered key and holds, takes the new entry or shifts.
// The response shows up in the cycle after the transfer from an output register.
// A new request is taken while the response register is empty or being drained.
// Reset (synchronous, active high) empties the queue and the response register.
// A stalled response stalls the request side; nothing is lost.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH,
   parameter int KEY_BITS    = spq_pkg::SPQ_KEY_BITS,
   parameter int TAG_BITS    = spq_pkg::SPQ_TAG_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spq_rsp_type         rsp_data_ff, rsp_data_in;

   logic                req_fire, is_full, is_empty;
   spq_cmd_type         cmd;
   logic [KEY_BITS-1:0] new_key;
   logic [TAG_BITS-1:0] new_tag;

   logic [KEY_BITS-1:0] cell_key  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tnext[QUEUE_DEPTH];
   logic                cell_keep [QUEUE_DEPTH];

   // Accept while the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign new_key = KEY_BITS'(req_data.priority_key);
   assign new_tag = TAG_BITS'(req_data.task_tag);

   // Decode the command for the chain
   assign cmd.insert = req_fire && (req_data.opcode == OP_OFFER) && !is_full;
   assign cmd.remove = req_fire && (req_data.opcode == OP_POLL) && !is_empty;

   // Build the chain of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                lkeep;
      logic [KEY_BITS-1:0] lkey, rkey;
      logic [TAG_BITS-1:0] ltag, rtag;

      if (i == 0) begin : g_first
         assign lkeep = 1'b1;
         assign lkey  = new_key;
         assign ltag  = new_tag;
      end else begin : g_mid
         assign lkeep = cell_keep[i-1];
         assign lkey  = cell_key[i-1];
         assign ltag  = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign rkey = '0;
         assign rtag = '0;
      end else begin : g_inner
         assign rkey = cell_key[i+1];
         assign rtag = cell_tag[i+1];
      end

      spq_cell #(
         .KEY_BITS (KEY_BITS),
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (CNT_BITS'(i) < count_ff),
         .new_key   (new_key),
         .new_tag   (new_tag),
         .left_keep (lkeep),
         .left_key  (lkey),
         .left_tag  (ltag),
         .right_key (rkey),
         .right_tag (rtag),
         .keep      (cell_keep[i]),
         .key       (cell_key[i]),
         .tag       (cell_tag[i]),
         .tag_next  (cell_tnext[i])
      );
   end

   // Advance the entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Form the response from the state after the step
   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_valid_in              = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.polled_tag    = cmd.remove ? 16'(cell_tag[0]) : 16'd0;
         rsp_data_in.polled_valid  = cmd.remove;
         rsp_data_in.offer_dropped = (req_data.opcode == OP_OFFER) && is_full;
         rsp_data_in.head_valid    = (count_in != '0);
         rsp_data_in.head_tag      = (count_in != '0) ? 16'(cell_tnext[0]) : 16'd0;
         rsp_data_in.entry_count   = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_BITS'(2) |-> cell_key[0] <= cell_key[1])
      else $error("head key above its successor");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.opcode == OP_OFFER && is_full |=>
         count_ff == CNT_BITS'(QUEUE_DEPTH) && rsp_data_ff.offer_dropped)
      else $error("offer to full queue not dropped");

   a_rsp_after_fire: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("transfer without response");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.polled_valid && rsp_data_ff.offer_dropped))
      else $error("poll and drop flagged together");
`endif

endmodule

FILE: tb/sorted_priority_queue_test.sv
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH     = SPQ_DEPTH;
   localparam int RESET_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 1225;
   localparam int BLOCK_ITEMS     = 40;
   localparam int MODE_ITEMS      = 64;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int REPORT_LIMIT    = 10;

   // One row of the directed table; when typed is set, rsp is the outcome to see
   typedef struct packed {
      spq_req_type req;
      logic        typed;
      spq_rsp_type rsp;
   } directed_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   spq_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   spq_rsp_type rsp_data;

   // Shadow copy of the sorted queue, slot 0 is the head
   logic [15:0] shadow_keys [QUEUE_DEPTH];
   logic [15:0] shadow_tags [QUEUE_DEPTH];
   int          shadow_count = 0;

   spq_rsp_type      due_outcomes [$];
   directed_row_type directed_rows [$];
   int               failures    = 0;
   int               idle_cycles = 0;

   sorted_priority_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Apply one request to the shadow queue and return the outcome it causes
   function automatic spq_rsp_type queue_outcome(input spq_req_type r);
      spq_rsp_type o;
      int          pos;
      int          i;
      o = '0;
      if (r.opcode == OP_OFFER) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            o.offer_dropped = 1'b1;
         end else begin
            // equal keys stay in arrival order: insert after every key <= new one
            pos = 0;
            while (pos < shadow_count && shadow_keys[pos] <= r.priority_key) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_tags[i] = shadow_tags[i-1];
            end
            shadow_keys[pos] = r.priority_key;
            shadow_tags[pos] = r.task_tag;
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         o.polled_tag   = shadow_tags[0];
         o.polled_valid = 1'b1;
         for (i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_tags[i-1] = shadow_tags[i];
         end
         shadow_count--;
      end
      o.head_valid  = (shadow_count > 0);
      o.head_tag    = (shadow_count > 0) ? shadow_tags[0] : 16'h0000;
      o.entry_count = shadow_count[4:0];
      return o;
   endfunction

   function automatic directed_row_type make_row(
      input logic op, input logic [15:0] key, input logic [15:0] tag, input logic typed,
      input logic [15:0] p_tag, input logic p_valid, input logic dropped,
      input logic [15:0] h_tag, input logic h_valid, input logic [4:0] count);
      directed_row_type row;
      row.req.opcode           = op;
      row.req.priority_key     = key;
      row.req.task_tag         = tag;
      row.typed                = typed;
      row.rsp.polled_tag       = p_tag;
      row.rsp.polled_valid     = p_valid;
      row.rsp.offer_dropped    = dropped;
      row.rsp.head_tag         = h_tag;
      row.rsp.head_valid       = h_valid;
      row.rsp.entry_count      = count;
      return row;
   endfunction

   function automatic logic [15:0] draw_key();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 7));
         1:       return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         2:       return 16'($urandom_range(0, 255));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Offer one request and hold it until the transfer, then record its outcome
   task automatic send_request(input spq_req_type r, input logic typed,
                               input spq_rsp_type literal, input int gap);
      spq_rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = queue_outcome(r);
      due_outcomes.push_back(typed ? literal : predicted);
   endtask

   // Compare one response transfer with the oldest outcome due
   task automatic check_response(input spq_rsp_type got);
      spq_rsp_type want;
      if (due_outcomes.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("unexpected response %h with nothing pending", got);
         return;
      end
      want = due_outcomes.pop_front();
      if (got.polled_tag !== want.polled_tag || got.polled_valid !== want.polled_valid ||
          got.offer_dropped !== want.offer_dropped || got.head_tag !== want.head_tag ||
          got.head_valid !== want.head_valid || got.entry_count !== want.entry_count) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $write("mismatch: polled_tag %h/%h polled_valid %b/%b dropped %b/%b ",
                   want.polled_tag, got.polled_tag, want.polled_valid, got.polled_valid,
                   want.offer_dropped, got.offer_dropped);
            $display("head_tag %h/%h head_valid %b/%b count %0d/%0d (expected/actual)",
                     want.head_tag, got.head_tag, want.head_valid, got.head_valid,
                     want.entry_count, got.entry_count);
         end
      end
   endtask

   // Drain responses with random stalls and one long hold-off
   initial begin : response_sink
      int gap;
      int seen;
      bit eager;
      seen  = 0;
      eager = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (seen % MODE_ITEMS == 0) eager = ($urandom_range(0, 2) == 0);
         gap = eager ? 0 : $urandom_range(0, 3);
         if (seen == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_response(rsp_data);
         seen++;
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : request_source
      spq_req_type item;
      int          n;
      int          offer_pct;
      bit          eager;

      // Empty poll, extreme keys and tags, equal keys in arrival order
      directed_rows.push_back(make_row(OP_POLL, 16'h0000, 16'h0000, 1'b1,
                                       16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 5'd0));
      directed_rows.push_back(make_row(OP_OFFER, 16'hFFFF, 16'hFFFF, 1'b1,
                                       16'h0000, 1'b0, 1'b0, 16'hFFFF, 1'b1, 5'd1));
      directed_rows.push_back(make_row(OP_OFFER, 16'h0000, 16'h0000, 1'b1,
                                       16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 5'd2));
      directed_rows.push_back(make_row(OP_OFFER, 16'h0000, 16'h1234, 1'b1,
                                       16'h0000, 1'b0, 1'b0, 16'h0000, 1'b1, 5'd3));
      directed_rows.push_back(make_row(OP_POLL, 16'h0000, 16'h0000, 1'b1,
                                       16'h0000, 1'b1, 1'b0, 16'h1234, 1'b1, 5'd2));
      directed_rows.push_back(make_row(OP_POLL, 16'hFFFF, 16'hFFFF, 1'b1,
                                       16'h1234, 1'b1, 1'b0, 16'hFFFF, 1'b1, 5'd1));
      directed_rows.push_back(make_row(OP_POLL, 16'h0000, 16'h0000, 1'b1,
                                       16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0, 5'd0));
      // Fill with keys out of order so entries land mid-list
      for (n = 0; n < QUEUE_DEPTH; n++)
         directed_rows.push_back(make_row(OP_OFFER, 16'(100 + (n * 7) % 16), 16'(16'hA000 + n),
                                          1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 5'd0));
      // Offer when full is dropped; the poll then exposes the next smallest key
      directed_rows.push_back(make_row(OP_OFFER, 16'h0000, 16'h5555, 1'b1,
                                       16'h0000, 1'b0, 1'b1, 16'hA000, 1'b1, 5'd16));
      directed_rows.push_back(make_row(OP_POLL, 16'h0000, 16'h0000, 1'b1,
                                       16'hA000, 1'b1, 1'b0, 16'hA007, 1'b1, 5'd15));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      eager = 1'b0;
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp,
                      $urandom_range(0, 3));

      // Random blocks lean toward filling, draining or neither
      offer_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) begin
            case ($urandom_range(0, 2))
               0:       offer_pct = 80;
               1:       offer_pct = 20;
               default: offer_pct = 50;
            endcase
         end
         if (n % MODE_ITEMS == 0) eager = ($urandom_range(0, 2) == 0);
         item.opcode       = ($urandom_range(0, 99) < offer_pct) ? OP_OFFER : OP_POLL;
         item.priority_key = draw_key();
         item.task_tag     = 16'($urandom_range(0, 16'hFFFF));
         send_request(item, 1'b0, '0, eager ? 0 : $urandom_range(0, 3));
      end
      req_valid <= 1'b0;

      // Wait out the remaining responses and the drain period, then report
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
